@@ hw/rtl/order_hash_table_engine_core_defines.svh @@
// Assertion macros used by the order hash table engine top level.
`ifndef ORDER_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define ORDER_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OHTE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OHTE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OHTE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define OHTE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hw/rtl/ohte_pkg.sv @@
// Types, codes and constants of the order hash table engine.
package ohte_pkg;

    localparam int DEF_ENTRIES     = 4096;
    localparam int DEF_BUCKETS     = 4096;
    localparam int DEF_CONTRACTS   = 64;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int MAX_BUCKET_W = 16;
    localparam int KEY_W        = 31;
    localparam int ID_W         = 64;
    localparam int PRICE_W      = 64;
    localparam int VOL_W        = 31;
    localparam int CONTRACT_W   = 6;
    localparam int CNT_W        = 32;
    localparam int INDEX_W      = 12;
    localparam int S_TDATA_W    = 208;
    localparam int M_TDATA_W    = 160;
    localparam int KEY_STEPS    = 8;
    localparam int STEP_W       = 3;

    localparam logic [2:0] ST_SUCCEEDED    = 3'd3;
    localparam logic [2:0] ST_CANCELED     = 3'd4;
    localparam logic [2:0] ST_REJECTED     = 3'd5;
    localparam logic [2:0] ST_INT_REJECTED = 3'd6;

    localparam logic [1:0] OC_OPEN        = 2'd0;
    localparam logic [1:0] OC_CLOSE_TODAY = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_STATUS = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_NO_FREE   = 2'd1,
        RC_NOT_FOUND = 2'd2
    } rc_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_REDUCE,
        FR_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_INS_WR,
        BK_INS_LINK,
        BK_LK_HEAD,
        BK_LK_WALK,
        BK_CNT,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic [CONTRACT_W-1:0] contract;
        logic [1:0]            oc;
        logic                  side;
        logic                  cancel;
        logic [2:0]            status;
    } attr_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
        attr_t              attr;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        cmd_t                    cmd;
        logic [MAX_BUCKET_W-1:0] bucket;
        logic [ID_W-1:0]         order_id;
        logic [CONTRACT_W-1:0]   contract;
        logic [PRICE_W-1:0]      price;
        logic [VOL_W-1:0]        volume;
        logic                    side;
        logic [1:0]              oc;
        logic [2:0]              status;
    } item_t;

    typedef struct packed {
        rc_t                   code;
        logic [INDEX_W-1:0]    index;
        logic [2:0]            status;
        logic                  cancel;
        logic                  removed;
        logic [VOL_W-1:0]      volume;
        logic [PRICE_W-1:0]    price;
        logic                  side;
        logic [1:0]            oc;
        logic [CONTRACT_W-1:0] contract;
        logic [CNT_W-1:0]      pending;
    } result_t;

endpackage

@@ hw/rtl/order_hash_table_engine_core.sv @@
// Top level of the order hash table engine: front, queue and back parts.
// The front accepts a word, runs eight key reduction steps of 4 bits each and hands the
// item to the queue; the back runs an insert through its write, link and output states
// and the other commands through head lookup, a chain walk, count and output states.
// The front takes a new word only after handing over the last one, and long chain walks
// slow the flow. Reset is synchronous; afterwards the bucket heads, free stack
// and counters are swept over max(BUCKETS, ENTRIES, 4*CONTRACTS) addresses, taking no input.
`include "order_hash_table_engine_core_defines.svh"
module order_hash_table_engine_core #(
    parameter int ENTRIES     = ohte_pkg::DEF_ENTRIES,
    parameter int BUCKETS     = ohte_pkg::DEF_BUCKETS,
    parameter int CONTRACTS   = ohte_pkg::DEF_CONTRACTS,
    parameter int QUEUE_DEPTH = ohte_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // command
    input  logic [1:0]                     s_tuser,
    // bucket_key, order_id, contract_index, price_bits, volume, side, category,
    // new_status
    input  logic [ohte_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_code
    output logic [1:0]                     m_tuser,
    // entry_index, order_status, cancel_pending, removed, stored_volume,
    // stored_price_bits, stored_side, stored_category, stored_contract, category_pending
    output logic [ohte_pkg::M_TDATA_W-1:0] m_tdata
);

    import ohte_pkg::*;

    logic    fq_valid, fq_ready, bq_valid, bq_pop, clr_busy;
    item_t   fq_item, bq_item;
    result_t m_res;

    ohte_front #(.BUCKETS(BUCKETS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .hold(clr_busy),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    ohte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(bq_valid), .rd_pop(bq_pop), .rd_item(bq_item)
    );

    ohte_back #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS), .CONTRACTS(CONTRACTS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bq_valid), .q_item(bq_item), .q_pop(bq_pop), .clr_busy(clr_busy),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(m_res)
    );

    assign m_tuser = m_res.code;
    assign m_tdata = {7'b0, m_res.pending, m_res.contract, m_res.oc, m_res.side,
                      m_res.price, m_res.volume, m_res.removed, m_res.cancel,
                      m_res.status, m_res.index};

    `OHTE_ASSERT_IMP(a_clear_blocks_input, aclk, aresetn, clr_busy, !s_tready)
    `OHTE_ASSERT_NEXT(a_clear_done_stays, aclk, aresetn, !clr_busy, !clr_busy)
    `OHTE_ASSERT_IMP(a_fail_is_empty, aclk, aresetn, m_tvalid && (m_res.code != RC_OK), m_tdata == '0)
    `OHTE_ASSERT_IMP(a_removed_no_cancel, aclk, aresetn, m_tvalid && m_res.removed, !m_res.cancel)

endmodule

@@ hw/rtl/ohte_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module ohte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ohte_front.sv @@
// Input stage: takes a word, unpacks it and reduces the key to a bucket.
module ohte_front #(
    parameter int BUCKETS = ohte_pkg::DEF_BUCKETS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           hold,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,
    input  logic [ohte_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           q_valid,
    input  logic                           q_ready,
    output ohte_pkg::item_t                q_item
);

    import ohte_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam logic [BW:0] BDIV = (BW + 1)'(BUCKETS);

    front_state_t      state_reg, state_next;
    item_t             item_reg, item_next;
    logic [KEY_W:0]    key_reg, key_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    function automatic logic [BW-1:0] mod_step(input logic [BW-1:0] r, input logic [3:0] d);
        logic [BW:0]   t;
        logic [BW-1:0] acc;
        acc = r;
        for (int i = 3; i >= 0; i--) begin
            t = {acc, d[i]};
            if (t >= BDIV) begin
                t = t - BDIV;
            end
            acc = t[BW-1:0];
        end
        return acc;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        item_reg <= item_next;
        key_reg  <= key_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        key_next   = key_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        q_valid    = 1'b0;
        unique case (state_reg)
            FR_IDLE: begin
                s_tready = !hold;
                if (s_tvalid && !hold) begin
                    item_next.cmd      = cmd_t'(s_tuser);
                    item_next.bucket   = '0;
                    item_next.order_id = s_tdata[94:31];
                    item_next.contract = s_tdata[100:95];
                    item_next.price    = s_tdata[164:101];
                    item_next.volume   = s_tdata[195:165];
                    item_next.side     = s_tdata[196];
                    item_next.oc       = s_tdata[198:197];
                    item_next.status   = s_tdata[201:199];
                    key_next           = {1'b0, s_tdata[30:0]};
                    rem_next           = '0;
                    step_next          = '0;
                    state_next         = FR_REDUCE;
                end
            end
            FR_REDUCE: begin
                rem_next  = mod_step(rem_reg, key_reg[KEY_W:KEY_W-3]);
                key_next  = key_reg << 4;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(KEY_STEPS - 1)) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                q_valid = 1'b1;
                if (q_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_comb begin
        q_item        = item_reg;
        q_item.bucket = MAX_BUCKET_W'(rem_reg);
    end

endmodule

@@ hw/rtl/ohte_queue.sv @@
// Short FIFO of classified items between the front and back parts.
module ohte_queue #(
    parameter int DEPTH = ohte_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ohte_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_pop,
    output ohte_pkg::item_t rd_item
);

    import ohte_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;
    assign rd_item  = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_wr) begin
            slots[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ hw/rtl/ohte_back.sv @@
// Execution stage: pool, chain and counter memories and the command sequencer.
module ohte_back #(
    parameter int ENTRIES   = ohte_pkg::DEF_ENTRIES,
    parameter int BUCKETS   = ohte_pkg::DEF_BUCKETS,
    parameter int CONTRACTS = ohte_pkg::DEF_CONTRACTS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  ohte_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              clr_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output ohte_pkg::result_t m_res
);

    import ohte_pkg::*;

    localparam int IW    = $clog2(ENTRIES);
    localparam int LW    = $clog2(ENTRIES + 1);
    localparam int BW    = $clog2(BUCKETS);
    localparam int NCNT  = CONTRACTS * 4;
    localparam int CAW   = $clog2(NCNT);
    localparam int SWEEP = (ENTRIES > BUCKETS) ? ((ENTRIES > NCNT) ? ENTRIES : NCNT)
                                               : ((BUCKETS > NCNT) ? BUCKETS : NCNT);
    localparam int SW    = $clog2(SWEEP);
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    back_state_t   state_reg, state_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic [LW-1:0] free_top_reg, free_top_next;
    item_t         item_reg, item_next;
    logic [IW-1:0] e_reg, e_next;
    logic [LW-1:0] h_reg, h_next;
    rec_t          rec_reg, rec_next;
    logic          rem_reg, rem_next;
    logic          slot_ok_reg, slot_ok_next;
    result_t       res_reg, res_next;
    logic          m_valid_reg, m_valid_next;
    result_t       m_res_reg, m_res_next;

    logic             rec_we, nxt_we, prv_we, head_we, stk_we, cnt_we;
    logic [IW-1:0]    rec_waddr, rec_raddr, nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
    logic [IW-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic [BW-1:0]    head_waddr, head_raddr;
    logic [CAW-1:0]   cnt_waddr, cnt_raddr;
    rec_t             rec_wdata, rec_rdata;
    logic [LW-1:0]    nxt_wdata, nxt_rdata, prv_wdata, prv_rdata, head_wdata, head_rdata;
    logic [CNT_W-1:0] cnt_wdata, cnt_rdata, cnt_sum;
    rec_t             rec_new, rec_upd;
    attr_t            a_upd;
    logic             rem_w;

    function automatic logic slot_ok(input attr_t a);
        return (a.oc != OC_CLOSE_TODAY) && (32'(a.contract) < CONTRACTS);
    endfunction

    function automatic logic [CAW-1:0] slot_of(input attr_t a);
        return CAW'({a.contract, a.side, a.oc != OC_OPEN});
    endfunction

    function automatic result_t make_res(input logic [IW-1:0] e, input rec_t r,
                                         input logic rem, input logic [CNT_W-1:0] pend);
        result_t res;
        res.code     = RC_OK;
        res.index    = INDEX_W'(e);
        res.status   = r.attr.status;
        res.cancel   = r.attr.cancel;
        res.removed  = rem;
        res.volume   = r.volume;
        res.price    = r.price;
        res.side     = r.attr.side;
        res.oc       = r.attr.oc;
        res.contract = r.attr.contract;
        res.pending  = pend;
        return res;
    endfunction

    ohte_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec_ram (
        .aclk(aclk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata)
    );
    ohte_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_nxt_ram (
        .aclk(aclk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
        .raddr(nxt_raddr), .rdata(nxt_rdata)
    );
    ohte_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prv_ram (
        .aclk(aclk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata)
    );
    ohte_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    ohte_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_stk_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );
    ohte_ram #(.WIDTH(CNT_W), .DEPTH(NCNT)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_CLEAR;
            clr_reg      <= '0;
            free_top_reg <= NIL;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            free_top_reg <= free_top_next;
            m_valid_reg  <= m_valid_next;
        end
        item_reg    <= item_next;
        e_reg       <= e_next;
        h_reg       <= h_next;
        rec_reg     <= rec_next;
        rem_reg     <= rem_next;
        slot_ok_reg <= slot_ok_next;
        res_reg     <= res_next;
        m_res_reg   <= m_res_next;
    end

    always_comb begin
        rec_new.id              = item_reg.order_id;
        rec_new.price           = item_reg.price;
        rec_new.volume          = item_reg.volume;
        rec_new.attr.contract   = item_reg.contract;
        rec_new.attr.oc         = item_reg.oc;
        rec_new.attr.side       = item_reg.side;
        rec_new.attr.cancel     = 1'b0;
        rec_new.attr.status     = '0;
        cnt_sum                 = cnt_rdata + CNT_W'(rec_reg.volume);

        a_upd = rec_rdata.attr;
        rem_w = 1'b0;
        unique case (item_reg.cmd)
            CMD_STATUS: begin
                a_upd.status = item_reg.status;
                case (item_reg.status) inside
                    ST_SUCCEEDED, ST_CANCELED: rem_w = 1'b1;
                    ST_REJECTED, ST_INT_REJECTED: begin
                        if (a_upd.cancel) begin
                            a_upd.cancel = 1'b0;
                        end else begin
                            rem_w = 1'b1;
                        end
                    end
                    default: ;
                endcase
                if (rem_w) begin
                    a_upd.cancel = 1'b0;
                end
            end
            CMD_CANCEL: a_upd.cancel = 1'b1;
            default: ;
        endcase
        rec_upd      = rec_rdata;
        rec_upd.attr = a_upd;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        free_top_next = free_top_reg;
        item_next     = item_reg;
        e_next        = e_reg;
        h_next        = h_reg;
        rec_next      = rec_reg;
        rem_next      = rem_reg;
        slot_ok_next  = slot_ok_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_res_next    = m_res_reg;
        q_pop         = 1'b0;

        rec_we     = 1'b0;
        rec_waddr  = e_reg;
        rec_wdata  = rec_upd;
        rec_raddr  = e_reg;
        nxt_we     = 1'b0;
        nxt_waddr  = e_reg;
        nxt_wdata  = nxt_rdata;
        nxt_raddr  = e_reg;
        prv_we     = 1'b0;
        prv_waddr  = e_reg;
        prv_wdata  = prv_rdata;
        prv_raddr  = e_reg;
        head_we    = 1'b0;
        head_waddr = item_reg.bucket[BW-1:0];
        head_wdata = nxt_rdata;
        head_raddr = q_item.bucket[BW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = IW'(free_top_reg);
        stk_wdata  = e_reg;
        stk_raddr  = IW'(free_top_reg - LW'(1));
        cnt_we     = 1'b0;
        cnt_waddr  = slot_of(rec_reg.attr);
        cnt_wdata  = cnt_sum;
        cnt_raddr  = slot_of(rec_upd.attr);

        unique case (state_reg)
            BK_CLEAR: begin
                head_we    = 32'(clr_reg) < BUCKETS;
                head_waddr = clr_reg[BW-1:0];
                head_wdata = NIL;
                stk_we     = 32'(clr_reg) < ENTRIES;
                stk_waddr  = clr_reg[IW-1:0];
                stk_wdata  = clr_reg[IW-1:0];
                cnt_we     = 32'(clr_reg) < NCNT;
                cnt_waddr  = clr_reg[CAW-1:0];
                cnt_wdata  = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SW'(SWEEP - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.cmd == CMD_INSERT) begin
                        if (free_top_reg == '0) begin
                            res_next      = '0;
                            res_next.code = RC_NO_FREE;
                            state_next    = BK_OUT;
                        end else begin
                            free_top_next = free_top_reg - LW'(1);
                            state_next    = BK_INS_WR;
                        end
                    end else begin
                        state_next = BK_LK_HEAD;
                    end
                end
            end
            BK_INS_WR: begin
                rec_we       = 1'b1;
                rec_waddr    = stk_rdata;
                rec_wdata    = rec_new;
                nxt_we       = 1'b1;
                nxt_waddr    = stk_rdata;
                nxt_wdata    = head_rdata;
                prv_we       = 1'b1;
                prv_waddr    = stk_rdata;
                prv_wdata    = NIL;
                head_we      = 1'b1;
                head_wdata   = LW'(stk_rdata);
                cnt_raddr    = slot_of(rec_new.attr);
                slot_ok_next = slot_ok(rec_new.attr);
                rec_next     = rec_new;
                e_next       = stk_rdata;
                h_next       = head_rdata;
                rem_next     = 1'b0;
                state_next   = BK_INS_LINK;
            end
            BK_INS_LINK: begin
                prv_we     = h_reg < NIL;
                prv_waddr  = IW'(h_reg);
                prv_wdata  = LW'(e_reg);
                cnt_we     = slot_ok_reg;
                res_next   = make_res(e_reg, rec_reg, 1'b0, slot_ok_reg ? cnt_sum : '0);
                state_next = BK_OUT;
            end
            BK_LK_HEAD: begin
                if (head_rdata >= NIL) begin
                    res_next      = '0;
                    res_next.code = RC_NOT_FOUND;
                    state_next    = BK_OUT;
                end else begin
                    rec_raddr  = IW'(head_rdata);
                    nxt_raddr  = IW'(head_rdata);
                    prv_raddr  = IW'(head_rdata);
                    e_next     = IW'(head_rdata);
                    state_next = BK_LK_WALK;
                end
            end
            BK_LK_WALK: begin
                if (rec_rdata.id == item_reg.order_id) begin
                    rec_we       = item_reg.cmd != CMD_QUERY;
                    rec_next     = rec_upd;
                    rem_next     = rem_w;
                    slot_ok_next = slot_ok(rec_upd.attr);
                    if (rem_w) begin
                        if (prv_rdata < NIL) begin
                            nxt_we    = 1'b1;
                            nxt_waddr = IW'(prv_rdata);
                        end else begin
                            head_we = 1'b1;
                        end
                        prv_we    = nxt_rdata < NIL;
                        prv_waddr = IW'(nxt_rdata);
                        if (free_top_reg < NIL) begin
                            stk_we        = 1'b1;
                            free_top_next = free_top_reg + LW'(1);
                        end
                    end
                    state_next = BK_CNT;
                end else if (nxt_rdata >= NIL) begin
                    res_next      = '0;
                    res_next.code = RC_NOT_FOUND;
                    state_next    = BK_OUT;
                end else begin
                    rec_raddr = IW'(nxt_rdata);
                    nxt_raddr = IW'(nxt_rdata);
                    prv_raddr = IW'(nxt_rdata);
                    e_next    = IW'(nxt_rdata);
                end
            end
            BK_CNT: begin
                res_next   = make_res(e_reg, rec_reg, rem_reg, slot_ok_reg ? cnt_rdata : '0);
                state_next = BK_OUT;
            end
            BK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign clr_busy = state_reg == BK_CLEAR;
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;

endmodule
